FILE: hw/rtl/rfr_pkg.sv
package rfr_pkg;

  localparam int unsigned UnitDepth = 65536;
  localparam int unsigned AddrW     = $clog2(UnitDepth);
  localparam int unsigned CntW      = AddrW + 1;
  localparam int unsigned QDepth    = 4;
  localparam int unsigned QPtrW     = $clog2(QDepth);
  localparam int unsigned QCntW     = QPtrW + 1;

  localparam logic [0:0] RegVideoMode = 1'b0;

  typedef enum logic [1:0] {
    CmdByte  = 2'd0,
    CmdLost  = 2'd1,
    CmdDrain = 2'd2,
    CmdNone  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ActHeader = 3'd0,
    ActIgnore = 3'd1,
    ActWhole  = 3'd2,
    ActFuHdr  = 3'd3,
    ActFuData = 3'd4,
    ActFuEnd  = 3'd5
  } act_e;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        out_last;
    logic [31:0] out_timestamp;
  } out_item_t;

endpackage

FILE: hw/rtl/rfr_front.sv
module rfr_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 video_mode_i,
  input  logic                 valid_i,
  input  logic [1:0]           cmd_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 pkt_last_i,
  output logic                 push_o,
  output rfr_pkg::out_item_t   push_item_o,
  output logic                 stage_busy_o
);

  logic [rfr_pkg::CntW-1:0] wc_q, wc_d;
  logic [rfr_pkg::CntW-1:0] ridx_q, ridx_d;
  logic                     reas_q, reas_d;
  logic                     ready_q, ready_d;
  logic                     sc_q, sc_d;
  logic [15:0]              pos_q, pos_d;
  logic [6:0]               hl_q, hl_d;
  logic [31:0]              ts_q, ts_d;
  rfr_pkg::act_e            act_q, act_d;
  logic [7:0]               nal_q, nal_d;

  logic                      we;
  logic [rfr_pkg::AddrW-1:0] waddr;
  logic [7:0]                wdata;
  logic                      rd_en;
  logic [rfr_pkg::AddrW-1:0] raddr;
  logic                      rd_const, rd_end;
  logic [7:0]                rd_cbyte;

  logic [7:0] mem_q [rfr_pkg::UnitDepth];
  logic [7:0] rd_data_q;

  logic        s1_valid_q;
  logic        s1_const_q;
  logic [7:0]  s1_cbyte_q;
  logic        s1_last_q;
  logic [31:0] s1_ts_q;

  always_comb begin
    logic       payload_wr;
    logic [7:0] pbyte;
    logic [7:0] b;
    b          = data_byte_i;
    payload_wr = 1'b0;
    pbyte      = b;
    wc_d   = wc_q;
    ridx_d = ridx_q;
    reas_d = reas_q;
    ready_d = ready_q;
    sc_d   = sc_q;
    pos_d  = pos_q;
    hl_d   = hl_q;
    ts_d   = ts_q;
    act_d  = act_q;
    nal_d  = nal_q;
    we     = 1'b0;
    waddr  = wc_q[rfr_pkg::AddrW-1:0];
    wdata  = b;
    rd_en  = 1'b0;
    raddr  = ridx_q[rfr_pkg::AddrW-1:0];
    rd_end = ({1'b0, ridx_q} + 1'b1) >= {1'b0, wc_q};
    rd_const = sc_q && (ridx_q < rfr_pkg::CntW'(4));
    rd_cbyte = (ridx_q == rfr_pkg::CntW'(3)) ? 8'h01 : 8'h00;

    if (valid_i) begin
      unique case (rfr_pkg::cmd_e'(cmd_i))
        rfr_pkg::CmdByte: begin
          if (pos_q == 16'd0) begin
            act_d = ready_q ? rfr_pkg::ActIgnore : rfr_pkg::ActHeader;
            hl_d  = 7'd12 + {1'b0, b[3:0], 2'b00};
          end
          priority case (act_d)
            rfr_pkg::ActHeader: begin
              if (pos_q >= 16'd4 && pos_q <= 16'd7) begin
                ts_d = {ts_q[23:0], b};
              end else if (pos_q >= {9'd0, hl_d}) begin
                if (!video_mode_i) begin
                  reas_d = 1'b0;
                  wc_d   = '0;
                  sc_d   = 1'b0;
                  act_d  = rfr_pkg::ActWhole;
                  payload_wr = 1'b1;
                end else if (b[4:0] >= 5'd1 && b[4:0] <= 5'd23) begin
                  reas_d = 1'b0;
                  wc_d   = rfr_pkg::CntW'(4);
                  sc_d   = 1'b1;
                  act_d  = rfr_pkg::ActWhole;
                  payload_wr = 1'b1;
                end else if (b[4:0] == 5'd28) begin
                  nal_d = b;
                  act_d = rfr_pkg::ActFuHdr;
                end else begin
                  act_d = rfr_pkg::ActIgnore;
                end
              end
            end
            rfr_pkg::ActFuHdr: begin
              if (b[7]) begin
                reas_d = 1'b1;
                wc_d   = rfr_pkg::CntW'(4);
                sc_d   = 1'b1;
                act_d  = rfr_pkg::ActFuData;
                pbyte  = (nal_q & 8'h60) | (b & 8'h1F);
                payload_wr = 1'b1;
              end else if (reas_q) begin
                act_d = b[6] ? rfr_pkg::ActFuEnd : rfr_pkg::ActFuData;
              end else begin
                act_d = rfr_pkg::ActIgnore;
              end
            end
            rfr_pkg::ActWhole, rfr_pkg::ActFuData, rfr_pkg::ActFuEnd: begin
              payload_wr = 1'b1;
            end
            default: ;
          endcase
          if (payload_wr) begin
            // drop the unit once it would overflow the store
            if (wc_d >= rfr_pkg::CntW'(rfr_pkg::UnitDepth)) begin
              wc_d   = '0;
              reas_d = 1'b0;
              act_d  = rfr_pkg::ActIgnore;
            end else begin
              we    = 1'b1;
              waddr = wc_d[rfr_pkg::AddrW-1:0];
              wdata = pbyte;
              wc_d  = wc_d + 1'b1;
            end
          end
          if (pos_q != 16'hFFFF) begin
            pos_d = pos_q + 16'd1;
          end
          if (pkt_last_i) begin
            if (act_d == rfr_pkg::ActWhole || (act_d == rfr_pkg::ActFuEnd && reas_d)) begin
              if (wc_d != '0) begin
                ready_d = 1'b1;
                ridx_d  = '0;
              end
              reas_d = 1'b0;
            end
            pos_d = '0;
            act_d = rfr_pkg::ActHeader;
          end
        end
        rfr_pkg::CmdLost: begin
          reas_d = 1'b0;
          if (!ready_q) begin
            wc_d = '0;
          end
          if (pos_q != 16'd0) begin
            act_d = rfr_pkg::ActIgnore;
          end
        end
        rfr_pkg::CmdDrain: begin
          if (ready_q) begin
            rd_en = 1'b1;
            if (rd_end) begin
              ready_d = 1'b0;
              ridx_d  = '0;
              wc_d    = '0;
            end else begin
              ridx_d = ridx_q + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wc_q       <= '0;
      ridx_q     <= '0;
      reas_q     <= 1'b0;
      ready_q    <= 1'b0;
      sc_q       <= 1'b0;
      pos_q      <= '0;
      hl_q       <= 7'd12;
      ts_q       <= '0;
      act_q      <= rfr_pkg::ActHeader;
      nal_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      wc_q       <= wc_d;
      ridx_q     <= ridx_d;
      reas_q     <= reas_d;
      ready_q    <= ready_d;
      sc_q       <= sc_d;
      pos_q      <= pos_d;
      hl_q       <= hl_d;
      ts_q       <= ts_d;
      act_q      <= act_d;
      nal_q      <= nal_d;
      s1_valid_q <= rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_data_q  <= mem_q[raddr];
      s1_const_q <= rd_const;
      s1_cbyte_q <= rd_cbyte;
      s1_last_q  <= rd_end;
      s1_ts_q    <= ts_q;
    end
  end

  assign push_o                    = s1_valid_q;
  assign push_item_o.out_byte      = s1_const_q ? s1_cbyte_q : rd_data_q;
  assign push_item_o.out_last      = s1_last_q;
  assign push_item_o.out_timestamp = s1_ts_q;
  assign stage_busy_o              = s1_valid_q;

endmodule

FILE: hw/rtl/rfr_queue.sv
module rfr_queue (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  rfr_pkg::out_item_t        push_item_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output rfr_pkg::out_item_t        item_o,
  output logic [rfr_pkg::QCntW-1:0] count_o
);

  rfr_pkg::out_item_t         slot_q [rfr_pkg::QDepth];
  logic [rfr_pkg::QPtrW-1:0]  wr_q, rd_q;
  logic [rfr_pkg::QCntW-1:0]  cnt_q;
  logic                       pop;

  assign valid_o = cnt_q != '0;
  assign pop     = valid_o && ready_i;
  assign item_o  = slot_q[rd_q];
  assign count_o = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + rfr_pkg::QCntW'(push_i) - rfr_pkg::QCntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= push_item_i;
    end
  end

endmodule

FILE: hw/rtl/rtp_h264_fua_reassembler.sv
// RTP depacketizer with H.264 FU-A reassembly. Each input item carries a
// command in tdata[1:0] (0 packet byte, 1 packet lost, 2 drain one byte) and
// a packet byte in tdata[9:2]; tlast marks the last byte of a packet. Headers
// (12 bytes plus 4 per CSRC) are stripped and the timestamp kept; in video
// mode single NAL units get a 00 00 00 01 start code and FU-A fragments are
// joined behind a rebuilt NAL header; in audio mode each payload is one unit.
// A finished unit sits in a 64 KiB single-port store and is read out one
// byte per drain item, with tlast on its final byte and the completing
// packet's timestamp alongside. One item is taken per clock; a drain result
// passes through the store read register and then a four-entry output queue,
// and input stalls only while the queued results plus a store read in flight
// add up to four.
module rtp_h264_fua_reassembler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // cmd[1:0], data_byte[9:2], zero fill
  input  logic        s_axis_tlast,   // pkt_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // out_byte[7:0], out_timestamp[39:8]
  output logic        m_axis_tlast    // out_last
);

  logic                      video_mode_q;
  logic                      push;
  rfr_pkg::out_item_t        push_item;
  rfr_pkg::out_item_t        q_item;
  logic [rfr_pkg::QCntW-1:0] q_count;
  logic                      stage_busy;

  assign pready = 1'b1;
  assign prdata = {31'd0, video_mode_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      video_mode_q <= 1'b1;
    end else if (psel && penable && pwrite && paddr[2] == rfr_pkg::RegVideoMode) begin
      video_mode_q <= pwdata[0];
    end
  end

  // hold input while the queue could not absorb a read already in flight
  assign s_axis_tready = ({1'b0, q_count} + {{rfr_pkg::QCntW{1'b0}}, stage_busy})
                         < (rfr_pkg::QCntW + 1)'(rfr_pkg::QDepth);

  rfr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .video_mode_i (video_mode_q),
    .valid_i      (s_axis_tvalid && s_axis_tready),
    .cmd_i        (s_axis_tdata[1:0]),
    .data_byte_i  (s_axis_tdata[9:2]),
    .pkt_last_i   (s_axis_tlast),
    .push_o       (push),
    .push_item_o  (push_item),
    .stage_busy_o (stage_busy)
  );

  rfr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .item_o      (q_item),
    .count_o     (q_count)
  );

  assign m_axis_tdata = {q_item.out_timestamp, q_item.out_byte};
  assign m_axis_tlast = q_item.out_last;

endmodule
